@@ sv/bb3_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Sizes of the line store and counters, the lane control bundle and the
// reciprocal table that turns the neighborhood sum into a truncated mean.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 16;
  localparam int ROW_W       = HEIGHT_W + 1;
  localparam int PEND_W      = WIDTH_W;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int WIN_N       = 9;
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam logic [WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = 16'd480;

  // Register index, taken from paddr bit 2.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [WIN_N-1:0][CH_W-1:0] pix9_t;

  typedef struct packed {
    logic               sum_en;
    logic               mul_en;
    logic [WIN_N-1:0]   mask;
    logic [CNT_W-1:0]   cnt;
  } lane_ctl_t;

  // ceil(2^16 / n); exact for every sum of nine 8-bit values.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

@@ sv/bb3_lane.sv @@
// ----------------------------------------------------------------------------
// bb3_lane: one color channel of the blur
// Sums the in-frame window values of its channel, then divides by the pixel
// count through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bb3_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bb3_pkg::lane_ctl_t     ctl_i,
  input  bb3_pkg::pix9_t         win_i,
  output logic [bb3_pkg::CH_W-1:0] mean_o
);
  import bb3_pkg::*;

  logic [SUM_W-1:0]  sum_d, sum_q;
  logic [PROD_W-1:0] prod;
  logic [CH_W-1:0]   mean_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (ctl_i.mask[i]) begin
        sum_d = sum_d + SUM_W'(win_i[i]);
      end
    end
  end

  assign prod = PROD_W'(sum_q) * PROD_W'(recip(ctl_i.cnt));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      mean_q <= '0;
    end else begin
      if (ctl_i.sum_en) begin
        sum_q <= sum_d;
      end
      if (ctl_i.mul_en) begin
        mean_q <= prod[RECIP_SHIFT +: CH_W];
      end
    end
  end

  assign mean_o = mean_q;

endmodule

@@ sv/bb3_merge.sv @@
// ----------------------------------------------------------------------------
// bb3_merge: output stage
// Joins the three lane means and the frame end flag into one output beat
// and holds it until the downstream side takes it.
// ----------------------------------------------------------------------------
module bb3_merge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      load_i,
  input  logic [bb3_pkg::CH_W-1:0]  red_i,
  input  logic [bb3_pkg::CH_W-1:0]  green_i,
  input  logic [bb3_pkg::CH_W-1:0]  blue_i,
  input  logic                      frame_end_i,
  output logic                      free_o,
  output logic                      m_tvalid_o,
  input  logic                      m_tready_i,
  output logic [bb3_pkg::PIX_W-1:0] m_tdata_o,
  output logic                      m_tlast_o
);
  import bb3_pkg::*;

  logic             valid_q;
  logic [PIX_W-1:0] data_q;
  logic             last_q;

  assign free_o = !valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_tready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= {blue_i, green_i, red_i};
      last_q <= frame_end_i;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tlast_o  = last_q;

endmodule

@@ sv/bb3_ctrl.sv @@
// ----------------------------------------------------------------------------
// bb3_ctrl: sequencer, line store and window
// Steps the raster position, reads and rewrites the two-row line store,
// shifts the 3x3 window and works out which neighbors lie in the frame.
// ----------------------------------------------------------------------------
module bb3_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_valid_i,
  output logic                         s_ready_o,
  input  logic                         s_op_i,
  input  logic [bb3_pkg::PIX_W-1:0]    s_pix_i,
  input  logic                         cfg_wr_i,
  input  logic [bb3_pkg::WIDTH_W-1:0]  eff_w_i,
  input  logic [bb3_pkg::HEIGHT_W-1:0] eff_h_i,
  input  logic                         out_free_i,
  output bb3_pkg::lane_ctl_t           lane_ctl_o,
  output logic [bb3_pkg::WIN_N-1:0][bb3_pkg::PIX_W-1:0] win_o,
  output logic                         frame_end_o,
  output logic                         load_o
);
  import bb3_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [COL_W-1:0]   cq_q, cq_d;
  logic [ROW_W-1:0]   rq_q, rq_d;
  logic [PEND_W-1:0]  pend_q, pend_d;
  logic               drain_q, drain_d;
  logic               last_q, last_d;
  logic [1:0]         tries_q, tries_d;
  logic [WIN_N-1:0]   mask_q, mask_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               fe_q, fe_d;
  logic [PIX_W-1:0]   px_q;

  // Each entry holds {row above, current row} for one column.
  logic [2*PIX_W-1:0] line_mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rdata_q;

  logic [WIN_N-1:0][PIX_W-1:0] win_q;

  logic               take_pix;
  logic [WIDTH_W-1:0] w_last;
  logic [ROW_W-1:0]   h_last;
  logic [WIDTH_W-1:0] cq_inc;
  logic               at_last;
  logic               case_edge, case_mid, emit;
  logic [ROW_W-1:0]   rc;
  logic [COL_W-1:0]   cc;
  logic               top_ok, bot_ok, left_ok, right_ok;
  logic [2:0]         row_ok, col_ok;
  logic [PEND_W-1:0]  pend_init;

  assign s_ready_o = (state_q == ST_IDLE);
  assign take_pix  = !s_op_i && (pend_q == '0);

  assign w_last    = eff_w_i - WIDTH_W'(1);
  assign h_last    = ROW_W'(eff_h_i) - ROW_W'(1);
  assign cq_inc    = WIDTH_W'(cq_q) + WIDTH_W'(1);
  assign at_last   = (WIDTH_W'(cq_q) == w_last) && (rq_q == h_last);
  assign pend_init = (eff_h_i == HEIGHT_W'(1)) ? eff_w_i : eff_w_i + WIDTH_W'(1);

  // At column 0 the right-hand pixel of the previous row is finished; the
  // shifted window then has that pixel in its middle column as well.
  assign case_edge = (cq_q == '0) && (rq_q >= ROW_W'(2));
  assign case_mid  = (cq_q != '0) && (rq_q != '0);
  assign emit      = case_edge || case_mid;
  assign rc        = case_edge ? rq_q - ROW_W'(2) : rq_q - ROW_W'(1);
  assign cc        = case_edge ? w_last[COL_W-1:0] : cq_q - COL_W'(1);

  assign top_ok   = (rc != '0);
  assign bot_ok   = (rc < h_last);
  assign left_ok  = (cc != '0);
  assign right_ok = (WIDTH_W'(cc) < w_last);
  assign row_ok   = {bot_ok, 1'b1, top_ok};
  assign col_ok   = {right_ok, 1'b1, left_ok};

  always_comb begin
    state_d = state_q;
    cq_d    = cq_q;
    rq_d    = rq_q;
    pend_d  = pend_q;
    drain_d = drain_q;
    last_d  = last_q;
    tries_d = tries_q;
    mask_d  = mask_q;
    cnt_d   = cnt_q;
    fe_d    = fe_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          if (take_pix) begin
            drain_d = 1'b0;
            last_d  = at_last;
            state_d = ST_RD;
          end else if (pend_q != '0) begin
            drain_d = 1'b1;
            tries_d = '0;
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (cq_inc >= eff_w_i) begin
          cq_d = '0;
          rq_d = rq_q + ROW_W'(1);
        end else begin
          cq_d = cq_inc[COL_W-1:0];
        end
        if (emit) begin
          cnt_d = '0;
          for (int i = 0; i < WIN_N; i++) begin
            mask_d[i] = row_ok[i / 3] && col_ok[i % 3];
            cnt_d     = cnt_d + CNT_W'(mask_d[i]);
          end
          fe_d = (rc == h_last) && (WIDTH_W'(cc) == w_last);
        end
        if (!drain_q) begin
          if (last_q) begin
            pend_d = pend_init;
          end
          state_d = emit ? ST_SUM : ST_IDLE;
        end else if (emit) begin
          pend_d = pend_q - PEND_W'(1);
          if (pend_q == PEND_W'(1)) begin
            cq_d = '0;
            rq_d = '0;
          end
          state_d = ST_SUM;
        end else begin
          tries_d = tries_q + 2'd1;
          state_d = (tries_q == 2'd2) ? ST_IDLE : ST_RD;
        end
      end
      ST_SUM: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // A register write starts a new frame.
    if (cfg_wr_i) begin
      cq_d   = '0;
      rq_d   = '0;
      pend_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cq_q    <= '0;
      rq_q    <= '0;
      pend_q  <= '0;
      drain_q <= 1'b0;
      last_q  <= 1'b0;
      tries_q <= '0;
      mask_q  <= '0;
      cnt_q   <= '0;
      fe_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cq_q    <= cq_d;
      rq_q    <= rq_d;
      pend_q  <= pend_d;
      drain_q <= drain_d;
      last_q  <= last_d;
      tries_q <= tries_d;
      mask_q  <= mask_d;
      cnt_q   <= cnt_d;
      fe_q    <= fe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_valid_i) begin
      px_q <= take_pix ? s_pix_i : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) begin
      rdata_q <= line_mem_q[cq_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      line_mem_q[cq_q] <= {rdata_q[PIX_W-1:0], px_q};
    end
  end

  // Window index is row * 3 + column; column 2 takes the new column.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (state_q == ST_UPD) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]     <= win_q[r*3 + 1];
        win_q[r*3 + 1] <= win_q[r*3 + 2];
      end
      win_q[2] <= rdata_q[2*PIX_W-1:PIX_W];
      win_q[5] <= rdata_q[PIX_W-1:0];
      win_q[8] <= px_q;
    end
  end

  assign lane_ctl_o.sum_en = (state_q == ST_SUM);
  assign lane_ctl_o.mul_en = (state_q == ST_MUL);
  assign lane_ctl_o.mask   = mask_q;
  assign lane_ctl_o.cnt    = cnt_q;
  assign win_o             = win_q;
  assign frame_end_o       = fe_q;
  assign load_o            = (state_q == ST_OUT) && out_free_i;

endmodule

@@ sv/box_blur_3x3_edge_aware_top.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_top: 3x3 box blur with in-frame neighbor count
// Raster RGB pixels in, per-channel truncated neighborhood means out, with
// drain beats to flush the results still owed at frame end.
//
//   Channel  Dir  Beat contents
//   s_axis   in   tdata: red, green, blue; tuser: operation (1 = drain)
//   m_axis   out  tdata: red, green, blue means; tlast: frame end
//   APB      in   frame_width at 0x0, frame_height at 0x4
//
// A pixel beat passes the line-store read and the window update; one with a
// result then also passes the sum and reciprocal-multiply steps of the channel
// lanes and waits for room in the result register. A drain beat that steps over
// positions without a result repeats the read and update for each step, until
// one gives a result or its retry counter runs out; one with nothing owed is dropped.
// The result register lets the next beat in while a result waits downstream.
// Reset is asynchronous; the line store needs no clearing pass.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [bb3_pkg::PIX_W-1:0]   s_axis_tdata_i,  // in_red, in_green, in_blue
  input  logic                        s_axis_tuser_i,  // operation
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [bb3_pkg::PIX_W-1:0]   m_axis_tdata_o,  // out_red, out_green, out_blue
  output logic                        m_axis_tlast_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::APB_AW-1:0]  paddr,
  input  logic [bb3_pkg::APB_DW-1:0]  pwdata,
  output logic [bb3_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bb3_pkg::*;

  logic [WIDTH_W-1:0]  fw_q;
  logic [HEIGHT_W-1:0] fh_q;
  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic                cfg_wr;
  logic [PIX_W-1:0]    s_pix;

  lane_ctl_t                   lane_ctl;
  logic [WIN_N-1:0][PIX_W-1:0] win;
  pix9_t                       win_r, win_g, win_b;
  logic [CH_W-1:0]             mean_r, mean_g, mean_b;
  logic                        frame_end, load, out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  fw_q <= pwdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= pwdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = APB_DW'(fw_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(fh_q);
      default:          prdata = '0;
    endcase
  end

  // Out-of-range sizes are pulled into the range the line store supports.
  assign eff_w = (fw_q == '0) ? WIDTH_W'(1) :
                 (fw_q > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : fw_q;
  assign eff_h = (fh_q == '0) ? HEIGHT_W'(1) : fh_q;

  // Internal pixel word is {red, green, blue}.
  assign s_pix = {s_axis_tdata_i[CH_W-1:0], s_axis_tdata_i[2*CH_W-1:CH_W],
                  s_axis_tdata_i[3*CH_W-1:2*CH_W]};

  bb3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_op_i      (s_axis_tuser_i),
    .s_pix_i     (s_pix),
    .cfg_wr_i    (cfg_wr),
    .eff_w_i     (eff_w),
    .eff_h_i     (eff_h),
    .out_free_i  (out_free),
    .lane_ctl_o  (lane_ctl),
    .win_o       (win),
    .frame_end_o (frame_end),
    .load_o      (load)
  );

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      win_r[i] = win[i][3*CH_W-1:2*CH_W];
      win_g[i] = win[i][2*CH_W-1:CH_W];
      win_b[i] = win[i][CH_W-1:0];
    end
  end

  bb3_lane u_lane_r (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .win_i  (win_r),
    .mean_o (mean_r)
  );

  bb3_lane u_lane_g (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .win_i  (win_g),
    .mean_o (mean_g)
  );

  bb3_lane u_lane_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (lane_ctl),
    .win_i  (win_b),
    .mean_o (mean_b)
  );

  bb3_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .red_i       (mean_r),
    .green_i     (mean_g),
    .blue_i      (mean_b),
    .frame_end_i (frame_end),
    .free_o      (out_free),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule

@@ tb/tb_box_blur_3x3_edge_aware_top.sv @@
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_edge_aware_top: self-checking bench for the 3x3 box blur
// Streams RGB frames of many sizes through the block and predicts every
// blurred pixel with an in-bench line-store and window model. Covers edge
// pixels, drain beats, frame-end flags, register writes with read-back,
// width and height clamping, back-pressure and random idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_edge_aware_top;
  import bb3_pkg::*;

  localparam int RANDOM_BEATS  = 250;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS   = 50;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } beat_op_e;

  // Matches the tdata layout: red in the lowest byte, blue in the highest.
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    pixel_t mean;
    logic   frame_end;
  } blur_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid_i;
  logic              s_axis_tready_o;
  logic [PIX_W-1:0]  s_axis_tdata_i;   // in_red, in_green, in_blue
  logic              s_axis_tuser_i;   // operation
  logic              m_axis_tvalid_o;
  logic              m_axis_tready_i;
  logic [PIX_W-1:0]  m_axis_tdata_o;   // out_red, out_green, out_blue
  logic              m_axis_tlast_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Blur model state.
  logic [WIDTH_W-1:0]  cfg_width;
  logic [HEIGHT_W-1:0] cfg_height;
  pixel_t              line_above [MAX_WIDTH];
  pixel_t              line_cur [MAX_WIDTH];
  pixel_t              win [3][3];
  int                  col_pos;
  int                  row_pos;
  int unsigned         owed;
  blur_result_t        mean_q [$];

  int  mismatches = 0;
  int  live_beats = 0;
  bit  src_burst = 1'b0;
  bit  sink_burst = 1'b0;
  int  sink_hold_req = 0;
  int  sink_stall_left = 0;

  always #2 clk_i = ~clk_i;

  box_blur_3x3_edge_aware_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic pixel_t rand_pixel();
    return pixel_t'($urandom);
  endfunction

  function automatic int eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
    return int'(cfg_width);
  endfunction

  function automatic int eff_height();
    return (cfg_height == 0) ? 1 : int'(cfg_height);
  endfunction

  // Mean around (rc, cc); window column base+d holds frame column cc+d.
  function automatic blur_result_t window_mean(int rc, int cc, int base);
    int w, h, r, c, wi, n;
    int sum_r, sum_g, sum_b;
    blur_result_t res;
    w = eff_width();
    h = eff_height();
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      r = rc + dr;
      if (r >= 0 && r < h) begin
        for (int dc = -1; dc <= 1; dc++) begin
          c = cc + dc;
          wi = base + dc;
          if (c >= 0 && c < w && wi >= 0 && wi <= 2) begin
            sum_r += win[dr+1][wi].red;
            sum_g += win[dr+1][wi].green;
            sum_b += win[dr+1][wi].blue;
            n++;
          end
        end
      end
    end
    if (n == 0) n = 1;
    res.mean.red   = CH_W'(sum_r / n);
    res.mean.green = CH_W'(sum_g / n);
    res.mean.blue  = CH_W'(sum_b / n);
    res.frame_end  = (rc == h - 1) && (cc == w - 1);
    return res;
  endfunction

  // Moves one pixel (real or a zero filler) into the window and line stores.
  function automatic bit shift_window(pixel_t px);
    int w;
    bit emitted;
    w = eff_width();
    emitted = 1'b0;
    // The right-edge pixel of a row is finished before the window shifts.
    if (col_pos == 0 && row_pos >= 2) begin
      mean_q = {mean_q, window_mean(row_pos - 2, w - 1, 2)};
      emitted = 1'b1;
    end
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_above[col_pos];
    win[1][2] = line_cur[col_pos];
    win[2][2] = px;
    line_above[col_pos] = line_cur[col_pos];
    line_cur[col_pos] = px;
    if (col_pos >= 1 && row_pos >= 1) begin
      mean_q = {mean_q, window_mean(row_pos - 1, col_pos - 1, 1)};
      emitted = 1'b1;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    return emitted;
  endfunction

  // Returns 1 unless the beat is a drain with nothing owed.
  function automatic bit predict_beat(beat_op_e op, pixel_t px);
    int w, h;
    bit last;
    int unsigned total;
    w = eff_width();
    h = eff_height();
    if (op == OP_PIXEL && owed == 0) begin
      last = (row_pos == h - 1) && (col_pos == w - 1);
      void'(shift_window(px));
      if (last) begin
        total = w * h;
        owed = (total < w + 1) ? total : w + 1;
      end
      return 1'b1;
    end
    if (owed == 0) return 1'b0;
    for (int tries = 0; tries < 3; tries++) begin
      if (shift_window('0)) begin
        owed--;
        if (owed == 0) begin
          col_pos = 0;
          row_pos = 0;
        end
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_beat(input beat_op_e op, input pixel_t px);
    int gap;
    gap = src_burst ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= px;
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    live_beats += predict_beat(op, px);
  endtask

  task automatic wait_results();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (mean_q.size() != 0);
  endtask

  // Beats that make no result may still be in flight when the queue empties.
  task automatic settle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] stored;
    if (idx == REG_FRAME_WIDTH) stored = APB_DW'(value[WIDTH_W-1:0]);
    else stored = APB_DW'(value[HEIGHT_W-1:0]);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (idx == REG_FRAME_WIDTH) cfg_width = value[WIDTH_W-1:0];
    else cfg_height = value[HEIGHT_W-1:0];
    col_pos = 0;
    row_pos = 0;
    owed = 0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== stored) begin
      report_mismatch($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                                idx, prdata, stored));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Unused upper bits of the write data carry noise that must be dropped.
  task automatic set_frame(input int w, input int h);
    settle();
    write_reg(REG_FRAME_WIDTH, ($urandom & ~((32'd1 << WIDTH_W) - 1)) | w);
    write_reg(REG_FRAME_HEIGHT, ($urandom & ~((32'd1 << HEIGHT_W) - 1)) | h);
  endtask

  task automatic send_pixels(input int n);
    for (int i = 0; i < n; i++) send_beat(OP_PIXEL, rand_pixel());
  endtask

  task automatic drain_frame();
    while (owed > 0) send_beat(OP_DRAIN, rand_pixel());
  endtask

  task automatic test_directed_edges();
    src_burst = 1'b0;
    sink_burst = 1'b0;
    set_frame(3, 2);
    send_beat(OP_DRAIN, '1);  // nothing owed yet, so ignored
    send_beat(OP_PIXEL, '{blue: 8'd0,   green: 8'd0,   red: 8'd0});
    send_beat(OP_PIXEL, '{blue: 8'd255, green: 8'd255, red: 8'd255});
    send_beat(OP_PIXEL, '{blue: 8'd0,   green: 8'd0,   red: 8'd255});
    send_beat(OP_PIXEL, '{blue: 8'd0,   green: 8'd255, red: 8'd0});
    send_beat(OP_PIXEL, '{blue: 8'd255, green: 8'd0,   red: 8'd0});
    send_beat(OP_PIXEL, '{blue: 8'd255, green: 8'd255, red: 8'd255});
    send_beat(OP_DRAIN, rand_pixel());
    // A pixel beat while results are owed only drains, its data is dropped.
    send_beat(OP_PIXEL, '1);
    drain_frame();
    send_beat(OP_DRAIN, rand_pixel());
    // Zero sizes act as a single-pixel frame.
    set_frame(0, 0);
    send_beat(OP_PIXEL, '{blue: 8'd255, green: 8'd128, red: 8'd1});
    drain_frame();
    send_beat(OP_DRAIN, rand_pixel());
    set_frame(1, 3);
    send_beat(OP_PIXEL, '1);
    send_beat(OP_PIXEL, '0);
    send_beat(OP_PIXEL, '1);
    drain_frame();
  endtask

  task automatic test_backpressure();
    set_frame(4, 8);
    src_burst = 1'b1;
    sink_burst = 1'b0;
    // Downstream stalls while the source keeps offering beats back to back.
    sink_hold_req = 300;
    send_pixels(16);
    wait_results();
    src_burst = 1'b0;
    send_pixels(16);
    drain_frame();
  endtask

  task automatic test_large_frames();
    src_burst = 1'b0;
    sink_burst = 1'b1;
    // Width above the line store size is clamped to it; the first results
    // only come out once the row wraps at the clamped width.
    set_frame((1 << WIDTH_W) - 1, 2);
    send_pixels(MAX_WIDTH + 4);
    sink_burst = 1'b0;
    // Tallest frame, abandoned after a few rows by the next write.
    set_frame(1, (1 << HEIGHT_W) - 1);
    send_pixels(40);
  endtask

  task automatic test_random_frames();
    int start, w, h, npix, cut, sel;
    bit must_write;
    start = live_beats;
    must_write = 1'b1;
    while (live_beats - start < RANDOM_BEATS) begin
      if (must_write || $urandom_range(0, 1) == 0) begin
        sel = $urandom_range(0, 19);
        if (sel == 0) w = 0;
        else if (sel < 16) w = $urandom_range(1, 12);
        else w = $urandom_range(13, 64);
        if ($urandom_range(0, 15) == 0) h = 0;
        else h = $urandom_range(1, (w > 12) ? 2 : 6);
        set_frame(w, h);
      end
      src_burst = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      npix = eff_width() * eff_height();
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, npix - 1) : npix;
      for (int i = 0; i < cut; i++) begin
        if ($urandom_range(0, 9) == 0) send_beat(OP_DRAIN, rand_pixel());
        send_beat(OP_PIXEL, rand_pixel());
      end
      must_write = (cut != npix);
      if (!must_write) begin
        while (owed > 0) begin
          if ($urandom_range(0, 6) == 0) send_beat(OP_PIXEL, rand_pixel());
          else send_beat(OP_DRAIN, rand_pixel());
        end
        if ($urandom_range(0, 3) == 0) send_beat(OP_DRAIN, rand_pixel());
      end
    end
  endtask

  // Result checker.
  always @(posedge clk_i) begin : check_results
    blur_result_t want;
    pixel_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = pixel_t'(m_axis_tdata_o);
      if (mean_q.size() == 0) begin
        report_mismatch($sformatf("result beat 0x%06h with none expected", m_axis_tdata_o));
      end else begin
        want = mean_q.pop_front();
        if (got.red !== want.mean.red)
          report_mismatch($sformatf("red %0d, expected %0d", got.red, want.mean.red));
        if (got.green !== want.mean.green)
          report_mismatch($sformatf("green %0d, expected %0d", got.green, want.mean.green));
        if (got.blue !== want.mean.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", got.blue, want.mean.blue));
        if (m_axis_tlast_o !== want.frame_end)
          report_mismatch($sformatf("tlast %0b, expected %0b", m_axis_tlast_o, want.frame_end));
      end
    end
  end

  // Downstream ready: random stalls, plus a long hold-off on request.
  initial begin : sink_ready
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req > 0) begin
        sink_stall_left = sink_hold_req;
        sink_hold_req = 0;
      end else if (sink_stall_left == 0 && !sink_burst && $urandom_range(0, 99) < 30) begin
        sink_stall_left = pick_gap();
      end
      if (sink_stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        sink_stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #16000000;
    $display("tb_box_blur_3x3_edge_aware_top NOT OK");
    $finish;
  end

  initial begin : run_tests
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= OP_PIXEL;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    cfg_width  = FRAME_WIDTH_RST;
    cfg_height = FRAME_HEIGHT_RST;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_above[i] = '0;
      line_cur[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) win[r][c] = '0;
    end
    col_pos = 0;
    row_pos = 0;
    owed = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_edges();
    test_backpressure();
    test_large_frames();
    test_random_frames();

    settle();
    if (mismatches == 0) begin
      $display("tb_box_blur_3x3_edge_aware_top OK");
    end else begin
      $display("tb_box_blur_3x3_edge_aware_top NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/bb3_pkg.sv
sv/bb3_lane.sv
sv/bb3_merge.sv
sv/bb3_ctrl.sv
sv/box_blur_3x3_edge_aware_top.sv
tb/tb_box_blur_3x3_edge_aware_top.sv
